// ===== src/cxfef_pkg.sv =====
package cxfef_pkg;

  localparam int unsigned AddrW      = 48;
  localparam int unsigned PosW       = 32;
  localparam int unsigned BackReach  = 4096;
  localparam int unsigned WinDepth   = 10;
  // LEA decision for p is taken when byte p+LeaLag arrives
  localparam int unsigned LeaLag     = 7;
  // boundaries are recorded with this lag (b = n - BndLag)
  localparam int unsigned BndLag     = 8;

  localparam logic [7:0] OpRexW    = 8'h48;
  localparam logic [7:0] OpRexWR   = 8'h4C;
  localparam logic [7:0] OpLea     = 8'h8D;
  localparam logic [7:0] ModRmMask = 8'hC7;
  localparam logic [7:0] ModRmRip  = 8'h05;
  localparam logic [7:0] OpInt3    = 8'hCC;
  localparam logic [7:0] OpMov     = 8'h8B;
  localparam logic [7:0] ModRmRsp  = 8'hC4;
  localparam logic [7:0] OpZero    = 8'h00;
  localparam logic [7:0] OpRet     = 8'hC3;

  typedef enum logic [0:0] {
    CFG_SECTION_BASE   = 1'b0,
    CFG_STRING_ADDRESS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [AddrW-1:0] entry_address;
    logic             found;
  } out_rsp_t;

  // window and boundary state after the current byte is shifted in
  typedef struct packed {
    logic [WinDepth-1:0][7:0] bytes;
    logic [WinDepth-1:0]      vld;
    logic [PosW-1:0]          pos;
    logic [PosW-1:0]          bnd;
    logic                     bnd_vld;
    logic                     bnd_kind;
  } scan_view_t;

  function automatic logic is_byte(input logic vld, input logic [7:0] b,
                                   input logic [7:0] v);
    return vld && (b == v);
  endfunction

endpackage

// ===== src/code_xref_function_entry_finder_unit.sv =====
// Channel  | Handshake               | Payload
// -------- | ----------------------- | ------------------------------------------
// in       | in_valid_i / in_ready_o | in_req_i   : code_byte, last_byte
// out      | out_valid_o/out_ready_i | out_rsp_o  : entry_address, found
// cfg      | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i (48 bits)
//
// One byte per cycle sustained while the result register is not blocked.
// A request is captured in an input register, then window shift, boundary
// tracking and LEA/address check run combinationally into the result register.
// Throughput is set by the single window/compare stage.
// Reset clears the stream state and both address registers to zero.
// The input stage stalls only when a result is due and the result
// register is still occupied and out_ready_i is low.
module code_xref_function_entry_finder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cxfef_pkg::in_req_t             in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cxfef_pkg::out_rsp_t            out_rsp_o,
  input  logic                           cfg_we_i,
  input  cxfef_pkg::cfg_idx_e            cfg_index_i,
  input  logic [cxfef_pkg::AddrW-1:0]    cfg_data_i
);

  logic [cxfef_pkg::AddrW-1:0] base_q, str_q;

  // input register
  logic                  in_vld_q;
  cxfef_pkg::in_req_t    in_q;

  // result register
  logic                  out_vld_q;
  cxfef_pkg::out_rsp_t   out_q;

  cxfef_pkg::scan_view_t       view;
  logic                        hit, done, res_hit, has_result, advance;
  logic [cxfef_pkg::AddrW-1:0] entry;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      str_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cxfef_pkg::CFG_SECTION_BASE:   base_q <= cfg_data_i;
        cxfef_pkg::CFG_STRING_ADDRESS: str_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cxfef_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_q.code_byte),
    .last_i (in_q.last_byte),
    .hit_i  (res_hit),
    .view_o (view),
    .done_o (done)
  );

  cxfef_match u_match (
    .view_i  (view),
    .base_i  (base_q),
    .str_i   (str_q),
    .hit_o   (hit),
    .entry_o (entry)
  );

  // after an entry is emitted the rest of the section is ignored
  assign res_hit    = hit && !done;
  assign has_result = !done && (hit || in_q.last_byte);
  assign advance    = in_vld_q && (!has_result || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_result) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q.found         <= res_hit;
      out_q.entry_address <= res_hit ? entry : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // not-found results always carry a zero address
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.found |-> out_q.entry_address == '0)
    else $error("not-found result with nonzero address");

  // the input stage only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |-> out_vld_q && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a hit locks the scan until the section ends
  a_hit_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_hit && !in_q.last_byte |=> done)
    else $error("scan not locked after hit");

  // the last byte always releases the scan
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.last_byte |=> !done)
    else $error("scan state not cleared at last byte");

endmodule

// ===== src/cxfef_track.sv =====
module cxfef_track (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  logic                   hit_i,
  output cxfef_pkg::scan_view_t  view_o,
  output logic                   done_o
);

  logic [cxfef_pkg::WinDepth-1:0][7:0] win_q, win_d;
  logic [cxfef_pkg::WinDepth-1:0]      vld_q, vld_d;
  logic [cxfef_pkg::PosW-1:0]          pos_q, bnd_q, bnd_d;
  logic                                bnd_vld_q, bnd_vld_d;
  logic                                bnd_kind_q, bnd_kind_d;
  logic                                done_q;
  logic                                cc_pair, mov_frame;

  always_comb begin
    win_d = {win_q[cxfef_pkg::WinDepth-2:0], byte_i};
    vld_d = {vld_q[cxfef_pkg::WinDepth-2:0], 1'b1};
  end

  // CC CC at b-1,b
  assign cc_pair = vld_d[8]
                && cxfef_pkg::is_byte(vld_d[9], win_d[9], cxfef_pkg::OpInt3)
                && cxfef_pkg::is_byte(vld_d[8], win_d[8], cxfef_pkg::OpInt3);

  // 48 8B C4 at b, preceded by CC, 00 or C3
  assign mov_frame = vld_d[8]
                && cxfef_pkg::is_byte(vld_d[8], win_d[8], cxfef_pkg::OpRexW)
                && cxfef_pkg::is_byte(vld_d[7], win_d[7], cxfef_pkg::OpMov)
                && cxfef_pkg::is_byte(vld_d[6], win_d[6], cxfef_pkg::ModRmRsp)
                && (cxfef_pkg::is_byte(vld_d[9], win_d[9], cxfef_pkg::OpInt3)
                 || cxfef_pkg::is_byte(vld_d[9], win_d[9], cxfef_pkg::OpZero)
                 || cxfef_pkg::is_byte(vld_d[9], win_d[9], cxfef_pkg::OpRet));

  always_comb begin
    bnd_d      = bnd_q;
    bnd_vld_d  = bnd_vld_q;
    bnd_kind_d = bnd_kind_q;
    if (cc_pair) begin
      bnd_d      = pos_q - cxfef_pkg::PosW'(cxfef_pkg::BndLag);
      bnd_vld_d  = 1'b1;
      bnd_kind_d = 1'b1;
    end else if (mov_frame) begin
      bnd_d      = pos_q - cxfef_pkg::PosW'(cxfef_pkg::BndLag);
      bnd_vld_d  = 1'b1;
      bnd_kind_d = 1'b0;
    end
  end

  always_comb begin
    view_o.bytes    = win_d;
    view_o.vld      = vld_d;
    view_o.pos      = pos_q;
    view_o.bnd      = bnd_d;
    view_o.bnd_vld  = bnd_vld_d;
    view_o.bnd_kind = bnd_kind_d;
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      pos_q      <= '0;
      bnd_vld_q  <= 1'b0;
      bnd_kind_q <= 1'b0;
      done_q     <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        vld_q      <= '0;
        pos_q      <= '0;
        bnd_vld_q  <= 1'b0;
        bnd_kind_q <= 1'b0;
        done_q     <= 1'b0;
      end else if (!done_q) begin
        vld_q      <= vld_d;
        pos_q      <= pos_q + cxfef_pkg::PosW'(1);
        bnd_vld_q  <= bnd_vld_d;
        bnd_kind_q <= bnd_kind_d;
        done_q     <= hit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !last_i && !done_q) begin
      win_q <= win_d;
      bnd_q <= bnd_d;
    end
  end

endmodule

// ===== src/cxfef_match.sv =====
module cxfef_match (
  input  cxfef_pkg::scan_view_t        view_i,
  input  logic [cxfef_pkg::AddrW-1:0]  base_i,
  input  logic [cxfef_pkg::AddrW-1:0]  str_i,
  output logic                         hit_o,
  output logic [cxfef_pkg::AddrW-1:0]  entry_o
);

  logic                          lea;
  logic [31:0]                   disp;
  logic [cxfef_pkg::AddrW-1:0]   disp_ext, target;
  logic [cxfef_pkg::PosW-1:0]    p, bnd_gap;
  logic                          in_reach;

  // slot k holds byte n-k; slot 7 valid implies slots 0..6 valid
  assign lea = view_i.vld[7]
            && (view_i.bytes[7] == cxfef_pkg::OpRexW
             || view_i.bytes[7] == cxfef_pkg::OpRexWR)
            && view_i.bytes[6] == cxfef_pkg::OpLea
            && (view_i.bytes[5] & cxfef_pkg::ModRmMask) == cxfef_pkg::ModRmRip;

  // little-endian disp32 at p+3..p+6
  assign disp     = {view_i.bytes[1], view_i.bytes[2], view_i.bytes[3], view_i.bytes[4]};
  assign disp_ext = {{(cxfef_pkg::AddrW-32){disp[31]}}, disp};

  assign p      = view_i.pos - cxfef_pkg::PosW'(cxfef_pkg::LeaLag);
  assign target = base_i + cxfef_pkg::AddrW'(p)
                + cxfef_pkg::AddrW'(cxfef_pkg::LeaLag) + disp_ext;

  assign bnd_gap  = p - view_i.bnd;
  assign in_reach = 64'(bnd_gap) < 64'(cxfef_pkg::BackReach);

  assign hit_o   = lea && (target == str_i) && view_i.bnd_vld && in_reach;
  assign entry_o = base_i + cxfef_pkg::AddrW'(view_i.bnd)
                 + cxfef_pkg::AddrW'(view_i.bnd_kind);

endmodule
